// ===== design/mflt_pkg.sv =====
// ----------------------------------------------------------------------------
// mflt_pkg
// Shared types, codes and decode functions of the Modbus frame length tracker.
// ----------------------------------------------------------------------------
package mflt_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_HDR_BYTES        = 3'd0;
    localparam logic [2:0] REG_CRC_BYTES        = 3'd1;
    localparam logic [2:0] REG_MAX_FRAME_LENGTH = 3'd2;
    localparam logic [2:0] REG_RETRY_LIMIT      = 3'd3;
    localparam logic [2:0] REG_MESSAGE_KIND     = 3'd4;

    // Register reset values.
    localparam logic [3:0] RST_HDR_BYTES        = 4'd1;
    localparam logic [1:0] RST_CRC_BYTES        = 2'd2;
    localparam logic [8:0] RST_MAX_FRAME_LENGTH = 9'd256;
    localparam logic [7:0] RST_RETRY_LIMIT      = 8'd3;
    localparam logic       RST_MESSAGE_KIND     = 1'b0;

    // Message kinds.
    localparam logic KIND_REQUEST  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    // Input commands.
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // Reported phase codes.
    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_FUNCTION = 2'd1;
    localparam logic [1:0] PH_META     = 2'd2;
    localparam logic [1:0] PH_DATA     = 2'd3;

    // Modbus function codes that change the framing.
    localparam logic [7:0] FC_READ_INPUT_REGS   = 8'd4;
    localparam logic [7:0] FC_WRITE_SINGLE_COIL = 8'd5;
    localparam logic [7:0] FC_WRITE_SINGLE_REG  = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_MULTI_REGS  = 8'd16;
    localparam logic [7:0] FC_REPORT_SERVER_ID  = 8'd17;

    // Meta part lengths.
    localparam logic [2:0] META_NONE   = 3'd0;
    localparam logic [2:0] META_SHORT  = 3'd1;
    localparam logic [2:0] META_FIXED  = 3'd4;
    localparam logic [2:0] META_MULTI  = 3'd5;

    // Offset of the byte-count byte past the header.
    localparam logic [4:0] COUNT_OFS_REQUEST  = 5'd5;
    localparam logic [4:0] COUNT_OFS_RESPONSE = 5'd1;

    typedef enum logic [1:0] {
        STEP_FUNCTION = 2'd0,
        STEP_META     = 2'd1,
        STEP_DATA     = 2'd2
    } step_t;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_MORE      = 3'd1,
        ST_DONE      = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    typedef struct packed {
        logic [3:0] hdr_bytes;
        logic [1:0] crc_bytes;
        logic [8:0] max_frame_length;
        logic [7:0] retry_limit;
        logic       message_kind;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [8:0] byte_index;
        logic [1:0] phase;
        logic [8:0] frame_length;
        logic [7:0] byte_out;
    } result_t;

    // Length of the meta part that follows the function code.
    function automatic logic [2:0] meta_length(input logic kind, input logic [7:0] fc);
        logic [2:0] m;
        if (kind == KIND_REQUEST) begin
            if (fc <= FC_WRITE_SINGLE_REG)
                m = META_FIXED;
            else if (fc == FC_WRITE_MULTI_COILS || fc == FC_WRITE_MULTI_REGS)
                m = META_MULTI;
            else
                m = META_NONE;
        end
        else begin
            if (fc == FC_WRITE_SINGLE_COIL || fc == FC_WRITE_SINGLE_REG
                || fc == FC_WRITE_MULTI_COILS || fc == FC_WRITE_MULTI_REGS)
                m = META_FIXED;
            else
                m = META_SHORT;
        end
        return m;
    endfunction

    // Data part length plus the trailing checksum.
    function automatic logic [8:0] data_length(input logic kind, input logic [7:0] fc,
                                               input logic [7:0] cb, input logic [1:0] chk);
        logic [7:0] n;
        n = 8'd0;
        if (kind == KIND_REQUEST) begin
            if (fc == FC_WRITE_MULTI_COILS || fc == FC_WRITE_MULTI_REGS)
                n = cb;
        end
        else begin
            if (fc <= FC_READ_INPUT_REGS || fc == FC_REPORT_SERVER_ID)
                n = cb;
        end
        return 9'(n) + 9'(chk);
    endfunction

endpackage

// ===== design/modbus_frame_length_tracker_core.sv =====
// ----------------------------------------------------------------------------
// modbus_frame_length_tracker_core
// Tracks received Modbus bytes and reports where each frame ends.
// ----------------------------------------------------------------------------
// The block takes one command per cycle (start, received byte or receive
// timeout) and returns one result per command. A command passes through an
// input register, one pass of decode logic against the frame state, and a
// result register that shows its result; a new command can follow in every
// cycle while the output is not stalled. The result register alone holds a
// result that waits to be taken; the input stalls only when both registers
// are full. Configuration writes are taken at any time and should be made
// while no command is in flight. No clearing pass is needed after reset.
module modbus_frame_length_tracker_core
    import mflt_pkg::*;
#(
    parameter int MAX_FRAME = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [8:0] byte_index, [10:9] phase,
                                   // [19:11] frame_length, [27:20] byte_out, rest zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t result;
    logic    advance;

    mflt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mflt_engine #(
        .MAX_FRAME (MAX_FRAME)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (in_item_reg),
        .advance (advance),
        .result  (result)
    );

    // Handshake: the held command moves on when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load on each transfer.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd       <= s_tuser;
            in_item_reg.data_byte <= s_tdata;
        end
        if (advance)
            out_res_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {4'd0, out_res_reg.byte_out, out_res_reg.frame_length,
                       out_res_reg.phase, out_res_reg.byte_index};

endmodule

// ===== design/mflt_cfg.sv =====
// ----------------------------------------------------------------------------
// mflt_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mflt_cfg
    import mflt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; writes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_HDR_BYTES:        cfg_next.hdr_bytes        = cfg_data[3:0];
                REG_CRC_BYTES:        cfg_next.crc_bytes        = cfg_data[1:0];
                REG_MAX_FRAME_LENGTH: cfg_next.max_frame_length = cfg_data[8:0];
                REG_RETRY_LIMIT:      cfg_next.retry_limit      = cfg_data[7:0];
                REG_MESSAGE_KIND:     cfg_next.message_kind     = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hdr_bytes        <= RST_HDR_BYTES;
            cfg_reg.crc_bytes        <= RST_CRC_BYTES;
            cfg_reg.max_frame_length <= RST_MAX_FRAME_LENGTH;
            cfg_reg.retry_limit      <= RST_RETRY_LIMIT;
            cfg_reg.message_kind     <= RST_MESSAGE_KIND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/mflt_engine.sv =====
// ----------------------------------------------------------------------------
// mflt_engine
// Frame state and the single-pass decode of one command into one result.
// ----------------------------------------------------------------------------
module mflt_engine
    import mflt_pkg::*;
#(
    parameter int MAX_FRAME = 512
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    advance,
    output result_t result
);

    localparam int CNT_W = $clog2(MAX_FRAME);
    localparam int SUM_W = ((CNT_W > 9) ? CNT_W : 9) + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAME - 1);

    // Frame state.
    step_t            step_reg,    step_next;
    logic [8:0]       rem_reg,     rem_next;
    logic [CNT_W-1:0] rcv_reg,     rcv_next;
    logic [7:0]       retries_reg, retries_next;
    logic [7:0]       fc_reg,      fc_next;
    logic [7:0]       cb_reg,      cb_next;
    logic             active_reg,  active_next;

    // Shared decode terms.
    logic [1:0]       cur_phase;
    logic [4:0]       count_pos;
    logic [7:0]       fc_new;
    logic [7:0]       cb_new;
    logic [CNT_W-1:0] rcv_inc;
    logic [8:0]       rem_dec;
    logic [2:0]       meta_len;
    logic [8:0]       data_len;
    logic [SUM_W-1:0] total;
    logic             go_meta;
    logic             to_data;
    logic             data_done;
    logic             too_long;
    logic             byte_frame_end;
    status_t          byte_status;

    // Byte decode: captures, counters and the end-of-part tests.
    always_comb
    begin
        unique case (step_reg)
            STEP_FUNCTION: cur_phase = (rcv_reg < CNT_W'(cfg.hdr_bytes)) ?
                                       PH_HEADER : PH_FUNCTION;
            STEP_META:     cur_phase = PH_META;
            default:       cur_phase = PH_DATA;
        endcase

        count_pos = 5'(cfg.hdr_bytes) + ((cfg.message_kind == KIND_REQUEST) ?
                    COUNT_OFS_REQUEST : COUNT_OFS_RESPONSE);
        fc_new = (step_reg == STEP_FUNCTION && rcv_reg == CNT_W'(cfg.hdr_bytes)) ?
                 item.data_byte : fc_reg;
        cb_new = (step_reg == STEP_META && rcv_reg == CNT_W'(count_pos)) ?
                 item.data_byte : cb_reg;

        rcv_inc = (rcv_reg < CNT_LAST) ? rcv_reg + 1'b1 : rcv_reg;
        rem_dec = (rem_reg != 9'd0) ? rem_reg - 9'd1 : 9'd0;

        meta_len = meta_length(cfg.message_kind, fc_new);
        data_len = data_length(cfg.message_kind, fc_new, cb_new, cfg.crc_bytes);
        total    = SUM_W'(rcv_inc) + SUM_W'(data_len);

        go_meta   = (rem_dec == 9'd0) && (step_reg == STEP_FUNCTION) && (meta_len != META_NONE);
        to_data   = (rem_dec == 9'd0) && ((step_reg == STEP_META)
                    || (step_reg == STEP_FUNCTION && meta_len == META_NONE));
        data_done = (rem_dec == 9'd0) && (step_reg == STEP_DATA);
        too_long  = to_data && (total > SUM_W'(cfg.max_frame_length)
                    || total > SUM_W'(MAX_FRAME - 1));

        if (too_long)
            byte_status = ST_TOO_LONG;
        else if (data_done || (to_data && data_len == 9'd0))
            byte_status = ST_DONE;
        else
            byte_status = ST_MORE;
        byte_frame_end = (byte_status != ST_MORE);
    end

    // Next state of the frame tracker.
    always_comb
    begin
        step_next    = step_reg;
        rem_next     = rem_reg;
        rcv_next     = rcv_reg;
        retries_next = retries_reg;
        fc_next      = fc_reg;
        cb_next      = cb_reg;
        active_next  = active_reg;
        unique case (item.cmd)
            CMD_START:
            begin
                step_next    = STEP_FUNCTION;
                rem_next     = 9'(cfg.hdr_bytes) + 9'd1;
                rcv_next     = '0;
                retries_next = cfg.retry_limit;
                fc_next      = 8'd0;
                cb_next      = 8'd0;
                active_next  = (cfg.retry_limit != 8'd0);
            end
            CMD_TIMEOUT:
            begin
                if (active_reg)
                begin
                    if (retries_reg <= 8'd1)
                    begin
                        retries_next = 8'd0;
                        active_next  = 1'b0;
                    end
                    else
                    begin
                        retries_next = retries_reg - 8'd1;
                    end
                end
            end
            CMD_BYTE:
            begin
                if (active_reg)
                begin
                    fc_next  = fc_new;
                    cb_next  = cb_new;
                    rcv_next = rcv_inc;
                    rem_next = rem_dec;
                    if (go_meta)
                    begin
                        step_next = STEP_META;
                        rem_next  = 9'(meta_len);
                    end
                    else if (to_data && !too_long)
                    begin
                        step_next = STEP_DATA;
                        rem_next  = data_len;
                    end
                    if (byte_frame_end)
                        active_next = 1'b0;
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    // Result of the current command.
    always_comb
    begin
        result.status       = ST_IGNORED;
        result.byte_index   = 9'(rcv_reg);
        result.phase        = cur_phase;
        result.frame_length = 9'(rcv_reg);
        result.byte_out     = 8'd0;
        unique case (item.cmd)
            CMD_START:
            begin
                result.status       = (cfg.retry_limit == 8'd0) ? ST_EXHAUSTED : ST_MORE;
                result.byte_index   = 9'd0;
                result.phase        = (cfg.hdr_bytes != 4'd0) ? PH_HEADER : PH_FUNCTION;
                result.frame_length = 9'd0;
            end
            CMD_TIMEOUT:
            begin
                if (active_reg)
                    result.status = (retries_reg <= 8'd1) ? ST_EXHAUSTED : ST_MORE;
            end
            CMD_BYTE:
            begin
                if (active_reg)
                begin
                    result.status       = byte_status;
                    result.frame_length = 9'(rcv_inc);
                    result.byte_out     = item.data_byte;
                end
            end
            default:
            begin
                result.status = ST_IGNORED;
            end
        endcase
    end

    // State registers advance once per transfer into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_FUNCTION;
            rem_reg     <= 9'd0;
            rcv_reg     <= '0;
            retries_reg <= 8'd0;
            fc_reg      <= 8'd0;
            cb_reg      <= 8'd0;
            active_reg  <= 1'b0;
        end
        else if (advance)
        begin
            step_reg    <= step_next;
            rem_reg     <= rem_next;
            rcv_reg     <= rcv_next;
            retries_reg <= retries_next;
            fc_reg      <= fc_next;
            cb_reg      <= cb_next;
            active_reg  <= active_next;
        end
    end

endmodule

// ===== design/mflt_checker.sv =====
// ----------------------------------------------------------------------------
// mflt_checker
// Port-level checks of the frame length tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mflt_checker
    import mflt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // The input stalls only behind a full, stalled result register.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output could move");

    // A completed frame ends on a byte that counts itself.
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_DONE) |-> (m_tdata[19:11] == m_tdata[8:0] + 9'd1))
        else $error("frame complete with a wrong length");

    // Retry exhaustion never carries a byte.
    a_exh_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_EXHAUSTED) |-> (m_tdata[27:20] == 8'd0))
        else $error("exhausted result carries a byte");

endmodule

bind modbus_frame_length_tracker_core mflt_checker u_mflt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
